>>> hw/rtl/sign_magnitude_fixed_point_alu_macros.svh
// Assertion helpers for the sign-magnitude fixed-point unit.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef SIGN_MAGNITUDE_FIXED_POINT_ALU_MACROS_SVH
`define SIGN_MAGNITUDE_FIXED_POINT_ALU_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define SMFP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SMFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/smfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smfp_pkg;

    // Field widths
    localparam int WHOLE_W  = 64;
    localparam int FRAC_W   = 64;
    localparam int MAG_W    = WHOLE_W + FRAC_W;
    localparam int STATUS_W = 3;
    localparam int OP_W     = 3;
    localparam int ORDER_W  = 2;

    // Stream word layouts
    localparam int S_FIELDS_W = 2 * (WHOLE_W + FRAC_W + STATUS_W);
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = WHOLE_W + FRAC_W + STATUS_W + ORDER_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB     = 3'd1;
    localparam logic [OP_W-1:0] OP_NEGATE  = 3'd2;
    localparam logic [OP_W-1:0] OP_HALVE   = 3'd3;
    localparam logic [OP_W-1:0] OP_DOUBLE  = 3'd4;
    localparam logic [OP_W-1:0] OP_COMPARE = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_POS     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEG     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVF_POS = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVF_NEG = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNF_POS = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNF_NEG = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ERROR   = 3'd6;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd7;

    // Compare outcomes (two's complement -1, 0, +1)
    localparam logic [ORDER_W-1:0] ORD_LESS    = 2'b11;
    localparam logic [ORDER_W-1:0] ORD_EQUAL   = 2'b00;
    localparam logic [ORDER_W-1:0] ORD_GREATER = 2'b01;

    typedef struct packed {
        logic [WHOLE_W-1:0]  whole;
        logic [FRAC_W-1:0]   frac;
        logic [STATUS_W-1:0] status;
    } smfp_operand_t;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        smfp_operand_t   a;
        smfp_operand_t   b;
    } smfp_item_t;

    typedef struct packed {
        logic [WHOLE_W-1:0]  whole;
        logic [FRAC_W-1:0]   frac;
        logic [STATUS_W-1:0] status;
        logic [ORDER_W-1:0]  order;
    } smfp_result_t;

    // Signed rank of a status for ordering by sign:
    // underflow neg < overflow neg < neg < invalid < pos < overflow pos
    // < underflow pos < error
    function automatic logic signed [3:0] status_rank(input logic [STATUS_W-1:0] s);
        logic signed [3:0] r;
        case (s)
            ST_POS:     r = 4'sd1;
            ST_NEG:     r = -4'sd1;
            ST_OVF_POS: r = 4'sd2;
            ST_OVF_NEG: r = -4'sd2;
            ST_UNF_POS: r = 4'sd3;
            ST_UNF_NEG: r = -4'sd3;
            ST_ERROR:   r = 4'sd4;
            default:    r = 4'sd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/smfp_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Single-pass datapath: one operation word in, one result word out.
module smfp_core
    import smfp_pkg::*;
(
    input  wire smfp_item_t item,
    output smfp_result_t    result
);

    logic [MAG_W-1:0]    a_mag;
    logic [MAG_W-1:0]    b_mag;
    logic [STATUS_W-1:0] a_st;
    logic [STATUS_W-1:0] b_st;
    logic [STATUS_W-1:0] b_st_eff;
    logic                a_valid;
    logic                b_valid;
    logic [MAG_W:0]      sum;
    logic [MAG_W:0]      a_minus_b;
    logic [MAG_W-1:0]    b_minus_a;
    logic                a_lt_b;
    logic                mag_eq;
    logic                a_gt_b;
    logic [MAG_W-1:0]    diff;
    logic [MAG_W-1:0]    halved;
    logic [MAG_W-1:0]    doubled;
    logic                rev;

    assign a_mag   = {item.a.whole, item.a.frac};
    assign b_mag   = {item.b.whole, item.b.frac};
    assign a_st    = item.a.status;
    assign b_st    = item.b.status;
    assign a_valid = (a_st == ST_POS) || (a_st == ST_NEG);
    assign b_valid = (b_st == ST_POS) || (b_st == ST_NEG);

    // Subtract flips the sign of a valid B
    assign b_st_eff = (item.operation == OP_SUB && b_valid) ? (b_st ^ 3'b001) : b_st;

    // Magnitude adder, subtractors and compare
    assign sum       = {1'b0, a_mag} + {1'b0, b_mag};
    assign a_minus_b = {1'b0, a_mag} - {1'b0, b_mag};
    assign b_minus_a = b_mag - a_mag;
    assign a_lt_b    = a_minus_b[MAG_W];
    assign mag_eq    = (a_mag == b_mag);
    assign a_gt_b    = !a_lt_b && !mag_eq;
    assign diff      = a_lt_b ? b_minus_a : a_minus_b[MAG_W-1:0];

    // Shifts by one place
    assign halved  = a_mag >> 1;
    assign doubled = a_mag << 1;

    // Negative kinds reverse the magnitude order
    assign rev = a_st[0] && (a_st != ST_INVALID);

    always_comb
    begin
        result.whole  = '0;
        result.frac   = '0;
        result.status = ST_INVALID;
        result.order  = ORD_EQUAL;
        unique case (item.operation) inside
            OP_ADD, OP_SUB:
            begin
                if (a_valid && b_valid)
                begin
                    if (a_st == b_st_eff)
                    begin
                        {result.whole, result.frac} = sum[MAG_W-1:0];
                        result.status = sum[MAG_W] ? (a_st | ST_OVF_POS) : a_st;
                    end
                    else
                    begin
                        {result.whole, result.frac} = diff;
                        if (mag_eq)
                            result.status = ST_POS;
                        else
                            result.status = a_lt_b ? b_st_eff : a_st;
                    end
                end
            end
            OP_NEGATE:
            begin
                {result.whole, result.frac} = a_mag;
                if (a_st == ST_POS && a_mag == '0)
                    result.status = a_st;
                else if (a_st == ST_ERROR || a_st == ST_INVALID)
                    result.status = a_st;
                else
                    result.status = a_st ^ 3'b001;
            end
            OP_HALVE:
            begin
                {result.whole, result.frac} = halved;
                result.status = (a_valid && item.a.frac[0]) ? (a_st | ST_UNF_POS) : a_st;
            end
            OP_DOUBLE:
            begin
                {result.whole, result.frac} = doubled;
                result.status = (a_valid && item.a.whole[WHOLE_W-1]) ?
                                (a_st | ST_OVF_POS) : a_st;
            end
            OP_COMPARE:
            begin
                result.status = ST_POS;
                if (a_st == b_st)
                begin
                    if (mag_eq)
                        result.order = ORD_EQUAL;
                    else if (a_gt_b)
                        result.order = rev ? ORD_LESS : ORD_GREATER;
                    else
                        result.order = rev ? ORD_GREATER : ORD_LESS;
                end
                else
                begin
                    result.order = (status_rank(a_st) > status_rank(b_st)) ?
                                   ORD_GREATER : ORD_LESS;
                end
            end
            default:
            begin
                result.status = ST_INVALID;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/sign_magnitude_fixed_point_alu.sv
// Sign-magnitude 64.64 fixed-point unit (add, subtract, negate, halve, double,
// compare). It takes one operation word per clock while the output is not
// stalled and returns exactly one result word per operation, in order. A word
// is held in the input register and its result in the result register; the
// 128-bit add/subtract and magnitude compare between them set the clock period.
// Under output back-pressure the input register still takes one word, so the
// unit holds at most two operations in flight.
`timescale 1ns / 1ps
`default_nettype none

module sign_magnitude_fixed_point_alu
    import smfp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // a_whole, a_frac, a_status, b_whole, b_frac, b_status, zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // operation
    input  wire logic [OP_W-1:0]      s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // result_whole, result_frac, result_status, order, zero pad
    output logic [M_TDATA_W-1:0]      m_tdata
);

    logic         in_vld_reg;
    logic         in_vld_next;
    smfp_item_t   in_item_reg;
    smfp_item_t   in_item;
    logic         out_vld_reg;
    logic         out_vld_next;
    smfp_result_t out_data_reg;
    smfp_result_t core_result;
    logic         s_accept;
    logic         out_adv;

    // Unpack the incoming word
    assign in_item.operation = s_tuser;
    assign in_item.a.whole   = s_tdata[WHOLE_W-1:0];
    assign in_item.a.frac    = s_tdata[WHOLE_W+FRAC_W-1:WHOLE_W];
    assign in_item.a.status  = s_tdata[MAG_W+STATUS_W-1:MAG_W];
    assign in_item.b.whole   = s_tdata[MAG_W+STATUS_W+WHOLE_W-1:MAG_W+STATUS_W];
    assign in_item.b.frac    = s_tdata[2*MAG_W+STATUS_W-1:MAG_W+STATUS_W+WHOLE_W];
    assign in_item.b.status  = s_tdata[2*MAG_W+2*STATUS_W-1:2*MAG_W+STATUS_W];

    // Handshake control
    assign out_adv  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || out_adv;
    assign s_accept = s_tvalid && s_tready;

    assign in_vld_next  = s_accept ? 1'b1 : (out_adv ? 1'b0 : in_vld_reg);
    assign out_vld_next = out_adv ? in_vld_reg : out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (s_accept)
            in_item_reg <= in_item;
    end

    smfp_core u_core
    (
        .item   (in_item_reg),
        .result (core_result)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (out_adv && in_vld_reg)
            out_data_reg <= core_result;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_TDATA_W-M_FIELDS_W){1'b0}},
                       out_data_reg.order, out_data_reg.status,
                       out_data_reg.frac, out_data_reg.whole};

endmodule

`default_nettype wire

>>> hw/rtl/smfp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sign_magnitude_fixed_point_alu_macros.svh"

module smfp_checker
    import smfp_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    logic [ORDER_W-1:0] order;
    logic               stalled;

    assign order   = m_tdata[M_FIELDS_W-1:M_FIELDS_W-ORDER_W];
    assign stalled = m_tvalid && !m_tready;

    // A stalled result word stays offered and unchanged
    `SMFP_ASSERT_NEXT(a_hold_valid, stalled, m_tvalid, "result word dropped while stalled")
    `SMFP_ASSERT_NEXT(a_hold_data, stalled, $stable(m_tdata), "result word changed while stalled")

    // A compare outcome never mixes with arithmetic fields and never uses code 2'b10
    `SMFP_ASSERT_SAME(a_order_alone, m_tvalid && order != ORD_EQUAL,
                      m_tdata[M_FIELDS_W-ORDER_W-1:0] == '0, "order set beside a value")
    `SMFP_ASSERT_SAME(a_order_code, m_tvalid, order != 2'b10, "order code out of range")

    // An empty unit always takes a word
    `SMFP_ASSERT_SAME(a_ready_empty, !m_tvalid && $past(!m_tvalid) && $past(!s_tvalid),
                      s_tready, "not ready while empty")

endmodule

bind sign_magnitude_fixed_point_alu smfp_checker u_smfp_checker (.*);

`default_nettype wire
